/* src/tff_pkg.sv */
// Tangent frame package: widths, codes and payload types shared by the
// tangent frame pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tff_pkg;

  localparam int FRAC_BITS = 14;
  localparam int TAG_W     = 20;
  localparam int IN_W      = 16;
  localparam int PROD_W    = 2 * IN_W;
  localparam int SQ_W      = PROD_W - 1;
  localparam int SUM_W     = PROD_W;
  localparam int PAD_W     = 16;
  localparam int RAD_W     = SUM_W + PAD_W;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQREM_W   = ROOT_W + 2;
  localparam int UNIT_SH   = FRAC_BITS + 8;
  localparam int PROD_SH   = 8;
  localparam int MAG_W     = (PROD_W - 1 + PROD_SH > IN_W + UNIT_SH) ?
                             (PROD_W - 1 + PROD_SH) : (IN_W + UNIT_SH);
  localparam int NUM_W     = MAG_W + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int DREM_W    = DEN_W + 1;
  localparam int LANES     = 6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_DIV  = 2'd1;
  localparam logic [1:0] KIND_NEGR = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic [1:0]               axis;
    logic                     deg;
    logic signed [IN_W-1:0]   nx;
    logic signed [IN_W-1:0]   ny;
    logic signed [IN_W-1:0]   nz;
    logic signed [PROD_W-1:0] pxy;
    logic signed [PROD_W-1:0] pxz;
    logic signed [PROD_W-1:0] pyz;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [RAD_W-1:0]   rad;
    logic [SQREM_W-1:0] rem;
    logic [ROOT_W-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic [TAG_W-1:0]                   tag;
    logic [1:0]                         axis;
    logic                               deg;
    logic [IN_W-1:0]                    negr;
    logic [DEN_W-1:0]                   den;
    logic [LANES-1:0][1:0]              kind;
    logic [LANES-1:0]                   neg;
    logic [LANES-1:0][NUM_W-1:0]        num;
    logic [LANES-1:0][DREM_W-1:0]       rem;
  } div_t;

endpackage
`default_nettype wire

/* src/tff_in_if.sv */
// Input channel of the tangent frame block: normal and point tag.
// Depends on tff_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tff_in_if import tff_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [TAG_W-1:0]       point_tag;
  logic signed [IN_W-1:0] normal_x;
  logic signed [IN_W-1:0] normal_y;
  logic signed [IN_W-1:0] normal_z;
  modport source (output valid, point_tag, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, point_tag, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

/* src/tff_out_if.sv */
// Output channel of the tangent frame block: two tangents and flags.
// Depends on tff_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tff_out_if import tff_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [TAG_W-1:0]       tag_out;
  logic signed [IN_W-1:0] tan1_x;
  logic signed [IN_W-1:0] tan1_y;
  logic signed [IN_W-1:0] tan1_z;
  logic signed [IN_W-1:0] tan2_x;
  logic signed [IN_W-1:0] tan2_y;
  logic signed [IN_W-1:0] tan2_z;
  logic [1:0]             axis_chosen;
  logic                   degenerate;
  modport source (output valid, tag_out, tan1_x, tan1_y, tan1_z, tan2_x, tan2_y, tan2_z,
                  axis_chosen, degenerate, input ready);
  modport sink (input valid, tag_out, tan1_x, tan1_y, tan1_z, tan2_x, tan2_y, tan2_z,
                axis_chosen, degenerate, output ready);
endinterface
`default_nettype wire

/* src/tff_sqrt_cell.sv */
// One cell of the square root chain: resolves one root bit per transfer.
// Depends on tff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tff_sqrt_cell import tff_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_up,
  output logic      ready_up,
  input  wire sq_t  data_up,
  output logic      valid,
  input  wire logic ready_dn,
  output sq_t       data
);

  logic [SQREM_W-1:0] rem_sh;
  logic [SQREM_W-1:0] trial;
  logic               ge;
  sq_t                data_next;

  assign ready_up = !valid || ready_dn;

  always_comb begin
    rem_sh = {data_up.rem[SQREM_W-3:0], data_up.rad[RAD_W-1 -: 2]};
    trial  = {data_up.root, 2'b01};
    ge     = rem_sh >= trial;
    data_next      = data_up;
    data_next.rad  = data_up.rad << 2;
    data_next.rem  = ge ? (rem_sh - trial) : rem_sh;
    data_next.root = {data_up.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_up;
    end
  end

  // advance payload only on a transfer from the left
  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

/* src/tff_div_cell.sv */
// One cell of the divider chain: one quotient bit for all six lanes.
// Depends on tff_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tff_div_cell import tff_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_up,
  output logic      ready_up,
  input  wire div_t data_up,
  output logic      valid,
  input  wire logic ready_dn,
  output div_t      data
);

  logic [LANES-1:0][DREM_W-1:0] rem_sh;
  logic [LANES-1:0]             ge;
  div_t                         data_next;

  assign ready_up = !valid || ready_dn;

  always_comb begin
    data_next = data_up;
    for (int k = 0; k < LANES; k++) begin
      rem_sh[k] = {data_up.rem[k][DREM_W-2:0], data_up.num[k][NUM_W-1]};
      ge[k]     = rem_sh[k] >= {1'b0, data_up.den};
      data_next.rem[k] = ge[k] ? (rem_sh[k] - {1'b0, data_up.den}) : rem_sh[k];
      data_next.num[k] = {data_up.num[k][NUM_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

/* src/tangent_frame_from_normal.sv */
// Tangent frame from a normal: builds two tangents orthogonal to the normal
// in signed Q2.14. Depends on tff_pkg, tff_in_if, tff_out_if, tff_sqrt_cell
// and tff_div_cell.
//
// One normal is taken per clock cycle while the output is not stalled, and
// every result passes 2 front stages, 24 square root cells, 1 set-up stage,
// 40 divider cells, 1 output register: depth set by the bit-serial square
// root and divider chains, each cell resolving one bit. Each cell holds its
// own item and hands it on as soon as its right neighbour is free, so a
// stalled output only stops the cells that are full; empty cells further up
// keep taking transfers. Zero normals give degenerate = 1, axis 0 and zero
// tangents. Results saturate to the signed 16-bit range.
`timescale 1ns / 1ps
`default_nettype none
module tangent_frame_from_normal import tff_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  tff_in_if.sink     normal_in,
  tff_out_if.source  frame_out
);

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [IN_W-1:0]   nx;
    logic signed [IN_W-1:0]   ny;
    logic signed [IN_W-1:0]   nz;
    logic [SQ_W-1:0]          xx;
    logic [SQ_W-1:0]          yy;
    logic [SQ_W-1:0]          zz;
    logic signed [PROD_W-1:0] pxy;
    logic signed [PROD_W-1:0] pxz;
    logic signed [PROD_W-1:0] pyz;
  } front_t;

  // magnitude of a normal component
  function automatic logic [IN_W-1:0] abs_n(input logic signed [IN_W-1:0] v);
    return v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
  endfunction

  // magnitude of a product of two components
  function automatic logic [PROD_W-2:0] abs_p(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] m;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    return m[PROD_W-2:0];
  endfunction

  // rounding numerator 2*|a| + R for a component over r
  function automatic logic [NUM_W-1:0] unit_num(input logic signed [IN_W-1:0] v,
                                                input logic [ROOT_W-1:0] r);
    logic [MAG_W-1:0] mag;
    mag = MAG_W'(abs_n(v)) << UNIT_SH;
    return {mag, 1'b0} + NUM_W'(r);
  endfunction

  function automatic logic [NUM_W-1:0] prod_num(input logic signed [PROD_W-1:0] v,
                                                input logic [ROOT_W-1:0] r);
    logic [MAG_W-1:0] mag;
    mag = MAG_W'(abs_p(v)) << PROD_SH;
    return {mag, 1'b0} + NUM_W'(r);
  endfunction

  // saturate a signed quotient to 16 bits
  function automatic logic [IN_W-1:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
    logic [IN_W-1:0] res;
    if (neg) begin
      res = (q >= NUM_W'(1 << (IN_W - 1))) ? {1'b1, {(IN_W-1){1'b0}}}
                                             : IN_W'(-q[IN_W-1:0]);
    end else begin
      res = (q > NUM_W'((1 << (IN_W - 1)) - 1)) ? {1'b0, {(IN_W-1){1'b1}}}
                                                  : q[IN_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stage A: squares and cross products
  // ---------------------------------------------------------------------
  logic   a_valid;
  logic   a_ready;
  front_t a_data;
  front_t a_next;
  logic signed [PROD_W-1:0] sq_x, sq_y, sq_z;

  logic b_ready;

  assign a_ready         = !a_valid || b_ready;
  assign normal_in.ready = a_ready;

  always_comb begin
    sq_x = normal_in.normal_x * normal_in.normal_x;
    sq_y = normal_in.normal_y * normal_in.normal_y;
    sq_z = normal_in.normal_z * normal_in.normal_z;
    a_next.tag = normal_in.point_tag;
    a_next.nx  = normal_in.normal_x;
    a_next.ny  = normal_in.normal_y;
    a_next.nz  = normal_in.normal_z;
    a_next.xx  = sq_x[SQ_W-1:0];
    a_next.yy  = sq_y[SQ_W-1:0];
    a_next.zz  = sq_z[SQ_W-1:0];
    a_next.pxy = normal_in.normal_x * normal_in.normal_y;
    a_next.pxz = normal_in.normal_x * normal_in.normal_z;
    a_next.pyz = normal_in.normal_y * normal_in.normal_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= normal_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && normal_in.valid) begin
      a_data <= a_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: branch choice on the exact sums, seed the root chain
  // ---------------------------------------------------------------------
  logic [ROOT_W:0] sq_v;
  logic [ROOT_W:0] sq_r;
  sq_t             sq_d [ROOT_W+1];
  sq_t             b_next;
  logic [SUM_W-1:0] s1, s2, s3, s_sel;

  assign b_ready = !sq_v[0] || sq_r[0];

  always_comb begin
    s1 = {1'b0, a_data.yy} + {1'b0, a_data.zz};
    s2 = {1'b0, a_data.xx} + {1'b0, a_data.zz};
    s3 = {1'b0, a_data.xx} + {1'b0, a_data.yy};
    b_next.side.tag = a_data.tag;
    b_next.side.nx  = a_data.nx;
    b_next.side.ny  = a_data.ny;
    b_next.side.nz  = a_data.nz;
    b_next.side.pxy = a_data.pxy;
    b_next.side.pxz = a_data.pxz;
    b_next.side.pyz = a_data.pyz;
    // ties go to the earlier axis
    priority if (s1 >= s2 && s1 >= s3) begin
      b_next.side.axis = AXIS_X;
      s_sel = s1;
    end else if (s2 >= s1 && s2 >= s3) begin
      b_next.side.axis = AXIS_Y;
      s_sel = s2;
    end else begin
      b_next.side.axis = AXIS_Z;
      s_sel = s3;
    end
    b_next.side.deg = (s_sel == '0);
    b_next.rad  = {s_sel, {PAD_W{1'b0}}};
    b_next.rem  = '0;
    b_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (b_ready) begin
      sq_v[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      sq_d[0] <= b_next;
    end
  end

  // ---------------------------------------------------------------------
  // Square root chain: one root bit per cell
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    tff_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_up (sq_v[i]),
      .ready_up (sq_r[i]),
      .data_up  (sq_d[i]),
      .valid    (sq_v[i+1]),
      .ready_dn (sq_r[i+1]),
      .data     (sq_d[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Set-up stage: lane numerators, divisor 2R and the -r entry
  // ---------------------------------------------------------------------
  localparam int DV_N = NUM_W;
  logic [DV_N:0] dv_v;
  logic [DV_N:0] dv_r;
  div_t          dv_d [DV_N+1];
  div_t          p_next;
  side_t         sd;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W:0]   root_rnd;
  logic [IN_W:0]     negr_mag;

  assign sq_r[ROOT_W] = !dv_v[0] || dv_r[0];

  always_comb begin
    sd       = sq_d[ROOT_W].side;
    root_r   = sq_d[ROOT_W].root;
    root_rnd = {1'b0, root_r} + (ROOT_W+1)'(128);
    negr_mag = root_rnd[ROOT_W -: (IN_W+1)];
    p_next.tag  = sd.tag;
    p_next.axis = sd.axis;
    p_next.deg  = sd.deg;
    p_next.negr = (negr_mag > (IN_W+1)'(1 << (IN_W - 1))) ? {1'b1, {(IN_W-1){1'b0}}}
                                                          : IN_W'((IN_W+1)'(0) - negr_mag);
    p_next.den  = {root_r, 1'b0};
    p_next.rem  = '0;
    p_next.num  = '0;
    p_next.neg  = '0;
    for (int k = 0; k < LANES; k++) begin
      p_next.kind[k] = KIND_ZERO;
    end
    if (!sd.deg) begin
      unique case (sd.axis)
        AXIS_X: begin
          p_next.kind[1] = KIND_DIV;  p_next.num[1] = unit_num(sd.nz, root_r);
          p_next.neg[1]  = sd.nz[IN_W-1];
          p_next.kind[2] = KIND_DIV;  p_next.num[2] = unit_num(sd.ny, root_r);
          p_next.neg[2]  = !sd.ny[IN_W-1];
          p_next.kind[3] = KIND_NEGR;
          p_next.kind[4] = KIND_DIV;  p_next.num[4] = prod_num(sd.pxy, root_r);
          p_next.neg[4]  = sd.pxy[PROD_W-1];
          p_next.kind[5] = KIND_DIV;  p_next.num[5] = prod_num(sd.pxz, root_r);
          p_next.neg[5]  = sd.pxz[PROD_W-1];
        end
        AXIS_Y: begin
          p_next.kind[0] = KIND_DIV;  p_next.num[0] = unit_num(sd.nz, root_r);
          p_next.neg[0]  = !sd.nz[IN_W-1];
          p_next.kind[2] = KIND_DIV;  p_next.num[2] = unit_num(sd.nx, root_r);
          p_next.neg[2]  = sd.nx[IN_W-1];
          p_next.kind[3] = KIND_DIV;  p_next.num[3] = prod_num(sd.pxy, root_r);
          p_next.neg[3]  = sd.pxy[PROD_W-1];
          p_next.kind[4] = KIND_NEGR;
          p_next.kind[5] = KIND_DIV;  p_next.num[5] = prod_num(sd.pyz, root_r);
          p_next.neg[5]  = sd.pyz[PROD_W-1];
        end
        default: begin
          p_next.kind[0] = KIND_DIV;  p_next.num[0] = unit_num(sd.ny, root_r);
          p_next.neg[0]  = sd.ny[IN_W-1];
          p_next.kind[1] = KIND_DIV;  p_next.num[1] = unit_num(sd.nx, root_r);
          p_next.neg[1]  = !sd.nx[IN_W-1];
          p_next.kind[3] = KIND_DIV;  p_next.num[3] = prod_num(sd.pxz, root_r);
          p_next.neg[3]  = sd.pxz[PROD_W-1];
          p_next.kind[4] = KIND_DIV;  p_next.num[4] = prod_num(sd.pyz, root_r);
          p_next.neg[4]  = sd.pyz[PROD_W-1];
          p_next.kind[5] = KIND_NEGR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (sq_r[ROOT_W]) begin
      dv_v[0] <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_r[ROOT_W] && sq_v[ROOT_W]) begin
      dv_d[0] <= p_next;
    end
  end

  // ---------------------------------------------------------------------
  // Divider chain: one quotient bit per cell, six lanes side by side
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < DV_N; j++) begin : g_div
    tff_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_up (dv_v[j]),
      .ready_up (dv_r[j]),
      .data_up  (dv_d[j]),
      .valid    (dv_v[j+1]),
      .ready_dn (dv_r[j+1]),
      .data     (dv_d[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: pick each entry by lane kind, saturate
  // ---------------------------------------------------------------------
  div_t                      dq;
  logic [LANES-1:0][IN_W-1:0] t_next;

  assign dv_r[DV_N] = !frame_out.valid || frame_out.ready;

  always_comb begin
    dq = dv_d[DV_N];
    for (int k = 0; k < LANES; k++) begin
      unique case (dq.kind[k])
        KIND_DIV:  t_next[k] = sat_q(dq.num[k], dq.neg[k]);
        KIND_NEGR: t_next[k] = dq.negr;
        default:   t_next[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_out.valid <= 1'b0;
    end else if (dv_r[DV_N]) begin
      frame_out.valid <= dv_v[DV_N];
    end
  end

  // hold the result until the transfer on the output side
  always_ff @(posedge clk) begin
    if (dv_r[DV_N] && dv_v[DV_N]) begin
      frame_out.tag_out     <= dq.tag;
      frame_out.tan1_x      <= t_next[0];
      frame_out.tan1_y      <= t_next[1];
      frame_out.tan1_z      <= t_next[2];
      frame_out.tan2_x      <= t_next[3];
      frame_out.tan2_y      <= t_next[4];
      frame_out.tan2_z      <= t_next[5];
      frame_out.axis_chosen <= dq.axis;
      frame_out.degenerate  <= dq.deg;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // a zero normal gives zero tangents on the first axis
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid && frame_out.degenerate |->
      frame_out.axis_chosen == AXIS_X && frame_out.tan1_x == '0 &&
      frame_out.tan1_y == '0 && frame_out.tan1_z == '0 && frame_out.tan2_x == '0 &&
      frame_out.tan2_y == '0 && frame_out.tan2_z == '0)
    else $error("degenerate result with non-zero tangent");

  // first tangent has no component along the chosen axis
  a_axis_zero: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid |->
      (frame_out.axis_chosen == AXIS_X && frame_out.tan1_x == '0) ||
      (frame_out.axis_chosen == AXIS_Y && frame_out.tan1_y == '0) ||
      (frame_out.axis_chosen == AXIS_Z && frame_out.tan1_z == '0))
    else $error("first tangent not orthogonal to chosen axis");

  // a full output stage with the sink stalled blocks the last divider cell
  a_stall_chain: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid && !frame_out.ready |-> !dv_r[DV_N])
    else $error("divider chain advances into a held result");

  // a non-degenerate x-axis result never has the -r entry as a positive value
  a_negr_sign: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid && !frame_out.degenerate && frame_out.axis_chosen == AXIS_X |->
      frame_out.tan2_x[IN_W-1] == 1'b1 || frame_out.tan2_x == '0)
    else $error("-r entry has wrong sign");

endmodule
`default_nettype wire

/* tb/tb_if.sv */
// Channel interfaces used by the testbench are those of the block itself;
// this file holds no extra interface. Depends on tff_pkg.
`timescale 1ns / 1ps
package tb_frame_pkg;
  import tff_pkg::*;

  typedef struct {
    logic [TAG_W-1:0]       tag;
    logic signed [IN_W-1:0] t1x, t1y, t1z, t2x, t2y, t2z;
    logic [1:0]             axis;
    logic                   deg;
  } frame_t;
endpackage

/* tb/tb.sv */
// Testbench top for tangent_frame_from_normal: directed table then random
// normals; results checked against typed rows or a bit-exact frame predictor.
// Depends on tff_pkg, tff_in_if, tff_out_if and tb_frame_pkg.
`timescale 1ns / 1ps
module tb;
  import tff_pkg::*;
  import tb_frame_pkg::*;

  localparam int LATENCY   = 68;
  localparam int N_RANDOM  = 1000;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tff_in_if  normal_in ();
  tff_out_if frame_out ();

  tangent_frame_from_normal dut (
    .clk(clk), .rst(rst), .normal_in(normal_in), .frame_out(frame_out)
  );

  frame_t expected_frames[$];
  int     errors = 0;
  int     cycles = 0;
  int     results_seen = 0;
  int     degenerate_seen = 0;
  bit     quiet_phase = 1'b0;   // long stretch with no idling on either side

  // Directed rows: normal and, where obvious, the expected frame.
  typedef struct {
    logic signed [15:0] nx, ny, nz;
    bit                 typed;
    frame_t             want;
  } row_t;

  // ---------------------------------------------------------------------
  // Predictor: exact integer arithmetic of the frame computation
  // ---------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // divide rounding to nearest, halves away from zero
  function automatic longint round_div(longint a, longint unsigned d);
    longint unsigned mag, q;
    mag = (a < 0) ? longint'(-a) : a;
    q = (2 * mag + d) / (2 * d);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic frame_t predict_frame(logic [TAG_W-1:0] tag,
                                           logic signed [15:0] ix,
                                           logic signed [15:0] iy,
                                           logic signed [15:0] iz);
    frame_t f;
    longint nx, ny, nz, unit, negr;
    longint unsigned s1, s2, s3, s, r;
    longint t[6];
    nx = ix; ny = iy; nz = iz;
    s1 = ny * ny + nz * nz;
    s2 = nx * nx + nz * nz;
    s3 = nx * nx + ny * ny;
    unit = longint'(1) << (FRAC_BITS + 8);
    foreach (t[i]) t[i] = 0;
    if (s1 >= s2 && s1 >= s3) begin
      f.axis = AXIS_X; s = s1;
    end else if (s2 >= s3) begin
      f.axis = AXIS_Y; s = s2;
    end else begin
      f.axis = AXIS_Z; s = s3;
    end
    f.tag = tag;
    f.deg = (s == 0);
    if (s != 0) begin
      r = int_sqrt(s << 16);
      negr = -longint'((r + 128) >> 8);
      case (f.axis)
        AXIS_X: begin
          t[1] = round_div(nz * unit, r);
          t[2] = round_div(-ny * unit, r);
          t[3] = negr;
          t[4] = round_div(nx * ny * 256, r);
          t[5] = round_div(nx * nz * 256, r);
        end
        AXIS_Y: begin
          t[0] = round_div(-nz * unit, r);
          t[2] = round_div(nx * unit, r);
          t[3] = round_div(nx * ny * 256, r);
          t[4] = negr;
          t[5] = round_div(ny * nz * 256, r);
        end
        default: begin
          t[0] = round_div(ny * unit, r);
          t[1] = round_div(-nx * unit, r);
          t[3] = round_div(nx * nz * 256, r);
          t[4] = round_div(ny * nz * 256, r);
          t[5] = negr;
        end
      endcase
    end
    f.t1x = clamp16(t[0]); f.t1y = clamp16(t[1]); f.t1z = clamp16(t[2]);
    f.t2x = clamp16(t[3]); f.t2y = clamp16(t[4]); f.t2z = clamp16(t[5]);
    return f;
  endfunction

  function automatic bit will_idle();
    return !quiet_phase && ($urandom_range(99) < 11);
  endfunction

  // ---------------------------------------------------------------------
  // Source side: present a normal, hold it until the transfer, advance
  // ---------------------------------------------------------------------
  task automatic send_normal(logic signed [15:0] nx, logic signed [15:0] ny,
                             logic signed [15:0] nz, bit typed, frame_t want);
    logic [TAG_W-1:0] tag;
    frame_t f;
    tag = TAG_W'($urandom);
    while (will_idle()) begin
      normal_in.valid <= 1'b0;
      @(posedge clk);
    end
    normal_in.valid     <= 1'b1;
    normal_in.point_tag <= tag;
    normal_in.normal_x  <= nx;
    normal_in.normal_y  <= ny;
    normal_in.normal_z  <= nz;
    do @(posedge clk); while (!normal_in.ready);
    f = predict_frame(tag, nx, ny, nz);
    if (typed) begin
      // typed rows carry their own expectation; tag comes from this transfer
      want.tag = tag;
      f = want;
    end
    expected_frames.push_back(f);
  endtask

  function automatic logic signed [15:0] random_component();
    case ($urandom_range(5))
      0: return 16'($urandom);                             // full range
      1: return 16'($urandom_range(16384) - 8192);         // small
      default: return 16'($urandom_range(32767) - 16384);  // near unit
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sink side: random back-pressure and comparison
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    frame_t e;
    if (rst) begin
      frame_out.ready <= 1'b0;
    end else begin
      if (frame_out.valid && frame_out.ready) begin
        results_seen++;
        if (frame_out.degenerate) degenerate_seen++;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result tag %h", $time, frame_out.tag_out);
          errors++;
        end else begin
          e = expected_frames.pop_front();
          if (frame_out.tag_out !== e.tag || frame_out.axis_chosen !== e.axis ||
              frame_out.degenerate !== e.deg ||
              frame_out.tan1_x !== e.t1x || frame_out.tan1_y !== e.t1y ||
              frame_out.tan1_z !== e.t1z || frame_out.tan2_x !== e.t2x ||
              frame_out.tan2_y !== e.t2y || frame_out.tan2_z !== e.t2z) begin
            $display("%0t: mismatch expected tag %h axis %0d deg %0b t1 %0d %0d %0d t2 %0d %0d %0d",
                     $time, e.tag, e.axis, e.deg, e.t1x, e.t1y, e.t1z, e.t2x, e.t2y, e.t2z);
            $display("%0t:          actual   tag %h axis %0d deg %0b t1 %0d %0d %0d t2 %0d %0d %0d",
                     $time, frame_out.tag_out, frame_out.axis_chosen, frame_out.degenerate,
                     frame_out.tan1_x, frame_out.tan1_y, frame_out.tan1_z,
                     frame_out.tan2_x, frame_out.tan2_y, frame_out.tan2_z);
            errors++;
          end
        end
      end
      frame_out.ready <= !will_idle();
    end
  end

  // Watchdog: generous bound against a hung pipeline
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tangent_frame_from_normal test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    row_t   rows[$];
    row_t   rw;
    frame_t z;
    int     k;
    normal_in.valid     = 1'b0;
    normal_in.point_tag = '0;
    normal_in.normal_x  = '0;
    normal_in.normal_y  = '0;
    normal_in.normal_z  = '0;

    // zero normal: degenerate, axis x, zero tangents
    z = '{tag: '0, t1x: 0, t1y: 0, t1z: 0, t2x: 0, t2y: 0, t2z: 0, axis: AXIS_X, deg: 1'b1};
    rows.push_back('{0, 0, 0, 1'b1, z});
    // unit z: axis x (ties to first), t1 = (0,1,0), t2 = (-1,0,0)
    z = '{tag: '0, t1x: 0, t1y: 16384, t1z: 0, t2x: -16384, t2y: 0, t2z: 0,
          axis: AXIS_X, deg: 1'b0};
    rows.push_back('{0, 0, 16384, 1'b1, z});
    // remaining rows go to the predictor: axes, extremes, ties, non-unit
    rows.push_back('{16384, 0, 0, 1'b0, z});
    rows.push_back('{0, 16384, 0, 1'b0, z});
    rows.push_back('{-16384, 0, 0, 1'b0, z});
    rows.push_back('{0, -16384, 0, 1'b0, z});
    rows.push_back('{0, 0, -16384, 1'b0, z});
    rows.push_back('{32767, 32767, 32767, 1'b0, z});
    rows.push_back('{-32768, -32768, -32768, 1'b0, z});
    rows.push_back('{-32768, 32767, 0, 1'b0, z});
    rows.push_back('{32767, 0, -32768, 1'b0, z});
    rows.push_back('{1, 0, 0, 1'b0, z});
    rows.push_back('{0, 0, -1, 1'b0, z});
    rows.push_back('{1, 1, 1, 1'b0, z});
    rows.push_back('{-1, 32767, -1, 1'b0, z});
    rows.push_back('{9459, 9459, 9459, 1'b0, z});
    rows.push_back('{11585, -11585, 0, 1'b0, z});
    rows.push_back('{100, 200, 300, 1'b0, z});
    rows.push_back('{-32768, 1, 1, 1'b0, z});   // saturating tangents
    rows.push_back('{1, 2, -32768, 1'b0, z});
    rows.push_back('{16'h5555, 16'shAAAA, 16'h7F00, 1'b0, z});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      rw = rows[i];
      send_normal(rw.nx, rw.ny, rw.nz, rw.typed, rw.want);
    end
    for (k = 0; k < N_RANDOM; k++) begin
      quiet_phase = (k >= 400 && k < 550);
      if ($urandom_range(49) == 0)
        send_normal(16'sd0, 16'sd0, 16'sd0, 1'b0, z);
      else
        send_normal(random_component(), random_component(), random_component(), 1'b0, z);
    end
    normal_in.valid <= 1'b0;

    while (expected_frames.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d directed and %0d random normals; %0d frames checked, %0d degenerate.",
             rows.size(), N_RANDOM, results_seen, degenerate_seen);
    if (errors == 0) begin
      $display("tangent_frame_from_normal test passed");
    end else begin
      $display("tangent_frame_from_normal test failed");
    end
    $finish;
  end
endmodule
